// File: rtl/elt_pkg.sv
// Shared types and constants for the echo level tracker.
`default_nettype none
package elt_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_SOUND_SPEED  = 3'd0,
		REG_MIN_DISTANCE = 3'd1,
		REG_MAX_DISTANCE = 3'd2,
		REG_TANK_HEIGHT  = 3'd3,
		REG_SENSOR_OFFSET = 3'd4,
		REG_SMOOTH_WEIGHT = 3'd5,
		REG_TREND_START  = 3'd6
	} reg_index_t;

	// Configuration register contents
	typedef struct packed {
		logic [15:0] sound_speed;
		logic [15:0] min_distance;
		logic [15:0] max_distance;
		logic [15:0] tank_height;
		logic [15:0] sensor_offset;
		logic [15:0] smoothing_weight;
		logic [4:0]  trend_start_count;
	} cfg_t;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 19;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Valid echo window, microseconds (exclusive bounds)
	localparam logic [15:0] ECHO_LOW  = 16'd100;
	localparam logic [15:0] ECHO_HIGH = 16'd45000;

	// Level class thresholds, hundredths of cm
	localparam logic [15:0] CLASS_HIGH_ABOVE = 16'd300;
	localparam logic [15:0] CLASS_MED_ABOVE  = 16'd150;
	localparam logic [15:0] CLASS_LOW_DIST   = 16'd800;

	// Weight of one in Q1.15
	localparam logic [15:0] WEIGHT_ONE = 16'd32768;

	// ceil(2^19 / 3): exact divide by three for sums below 2^19
	localparam logic [23:0] RECIP_THREE = 24'd174763;
	localparam int RECIP_SHIFT = 19;

	// Level class codes
	typedef enum logic [1:0] {
		CLASS_HIGH   = 2'd0,
		CLASS_MEDIUM = 2'd1,
		CLASS_LOW    = 2'd2,
		CLASS_EMPTY  = 2'd3
	} level_class_t;

	// Reset values of the registers
	localparam logic [15:0] RST_SOUND_SPEED  = 16'd2248;
	localparam logic [15:0] RST_MIN_DISTANCE = 16'd200;
	localparam logic [15:0] RST_MAX_DISTANCE = 16'd40000;
	localparam logic [15:0] RST_TANK_HEIGHT  = 16'd10000;
	localparam logic [15:0] RST_SENSOR_OFFSET = 16'd0;
	localparam logic [15:0] RST_SMOOTH_WEIGHT = 16'd6554;
	localparam logic [4:0]  RST_TREND_START  = 5'd3;

endpackage
`default_nettype wire

// File: rtl/elt_cfg.sv
// Configuration register file of the echo level tracker.
`default_nettype none
module elt_cfg
	import elt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sound_speed       <= RST_SOUND_SPEED;
			cfg_q.min_distance      <= RST_MIN_DISTANCE;
			cfg_q.max_distance      <= RST_MAX_DISTANCE;
			cfg_q.tank_height       <= RST_TANK_HEIGHT;
			cfg_q.sensor_offset     <= RST_SENSOR_OFFSET;
			cfg_q.smoothing_weight  <= RST_SMOOTH_WEIGHT;
			cfg_q.trend_start_count <= RST_TREND_START;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SOUND_SPEED:   cfg_q.sound_speed       <= cfg_data;
				REG_MIN_DISTANCE:  cfg_q.min_distance      <= cfg_data;
				REG_MAX_DISTANCE:  cfg_q.max_distance      <= cfg_data;
				REG_TANK_HEIGHT:   cfg_q.tank_height       <= cfg_data;
				REG_SENSOR_OFFSET: cfg_q.sensor_offset     <= cfg_data;
				REG_SMOOTH_WEIGHT: cfg_q.smoothing_weight  <= cfg_data;
				REG_TREND_START:   cfg_q.trend_start_count <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: rtl/elt_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module elt_mul
	import elt_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] op_a,
	input  wire logic signed [MUL_B_W-1:0] op_b,
	output logic signed [MUL_P_W-1:0]      prod
);

	logic signed [MUL_P_W-1:0] prod_q;

	// One product per cycle, registered
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

// File: rtl/echo_level_tracker.sv
// Top level of the echo level tracker: sequencer, state and result register.
//
// Converts one echo pulse width (microseconds) into a clamped distance, a
// clamped water height, an exponential moving average of the height, a
// trend (mean of the last three heights minus the average) and a four-way
// level class. Lengths are in hundredths of a centimetre. One input word
// is taken at a time; in_stall stays high after a word is accepted while a
// sequencer runs one shared multiplier three times (echo times sound speed,
// the weighted average step, the divide by three) and waits in DONE for a
// free result register, which lets a finished result wait while the next
// word is taken. The user must write configuration only while the block is
// idle; the block itself does not enforce it.
`default_nettype none
module echo_level_tracker
	import elt_pkg::*;
#(
	parameter int HISTORY_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// Input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] echo_width,
	// Output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      distance,
	output logic [15:0]      water_height,
	output logic [15:0]      smoothed_height,
	output logic [16:0]      height_trend,
	output logic [1:0]       level_class
);

	// Sample count saturates at the history depth, at most 31
	localparam int COUNT_CAP_I = (HISTORY_DEPTH > 31) ? 31 : HISTORY_DEPTH;
	localparam logic [4:0] COUNT_CAP = 5'(COUNT_CAP_I);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIST,
		S_CLAMP,
		S_HEIGHT,
		S_AVG,
		S_UPD,
		S_DIV,
		S_TREND,
		S_DONE
	} state_t;

	cfg_t cfg;
	state_t state_q;

	logic [15:0] echo_q;
	logic [15:0] dist_q;
	logic [15:0] height_q;
	logic [15:0] avg_q;
	logic [16:0] trend_q;
	logic [15:0] hist0_q;
	logic [15:0] hist1_q;
	logic [4:0]  count_q;
	logic [17:0] sum_q;

	logic        out_valid_q;
	logic [15:0] out_dist_q;
	logic [15:0] out_height_q;
	logic [15:0] out_avg_q;
	logic [16:0] out_trend_q;
	logic [1:0]  out_class_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;

	logic        echo_ok;
	logic [21:0] echo50;
	logic [21:0] raw;
	logic [15:0] dist_c;
	logic signed [17:0] h_raw;
	logic [15:0] height_c;
	logic [15:0] weight;
	logic signed [16:0] avg_diff;
	logic [4:0]  count_next;
	logic [15:0] quot;
	logic [1:0]  class_c;
	logic        out_free;

	elt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	elt_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	// Echo scaled by 50 with shifts; zero outside the valid window
	assign echo_ok = (echo_q > ECHO_LOW) && (echo_q < ECHO_HIGH);
	assign echo50  = {1'b0, echo_q, 5'b0} + {2'b0, echo_q, 4'b0} + {5'b0, echo_q, 1'b0};

	// Distance clamp on the raw product; with a crossed clamp pair a raw value below min gives min, any other gives max
	assign raw = prod[37:16];
	always_comb begin
		if (raw < {6'b0, cfg.min_distance})
			dist_c = cfg.min_distance;
		else if (raw > {6'b0, cfg.max_distance})
			dist_c = cfg.max_distance;
		else
			dist_c = raw[15:0];
	end

	// Height clamp to 0..tank_height
	assign h_raw = $signed({2'b0, cfg.tank_height}) - $signed({2'b0, dist_q})
		+ $signed({2'b0, cfg.sensor_offset});
	always_comb begin
		if (h_raw < 0)
			height_c = '0;
		else if (h_raw > $signed({2'b0, cfg.tank_height}))
			height_c = cfg.tank_height;
		else
			height_c = h_raw[15:0];
	end

	// Average step: avg + floor(w * (h - avg) / 2^15)
	assign weight   = (cfg.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smoothing_weight;
	assign avg_diff = $signed({1'b0, height_q}) - $signed({1'b0, avg_q});

	assign count_next = (count_q < COUNT_CAP) ? count_q + 5'd1 : count_q;
	assign quot = prod[RECIP_SHIFT+15:RECIP_SHIFT];

	// Level class
	always_comb begin
		if (height_q > CLASS_HIGH_ABOVE)
			class_c = CLASS_HIGH;
		else if (height_q > CLASS_MED_ABOVE)
			class_c = CLASS_MEDIUM;
		else if (dist_q <= CLASS_LOW_DIST)
			class_c = CLASS_LOW;
		else
			class_c = CLASS_EMPTY;
	end

	// Multiplier operand select
	always_comb begin
		case (state_q)
			S_DIST: begin
				mul_a = echo_ok ? $signed({2'b0, echo50}) : '0;
				mul_b = $signed({3'b0, cfg.sound_speed});
			end
			S_AVG: begin
				mul_a = MUL_A_W'(avg_diff);
				mul_b = $signed({3'b0, weight});
			end
			S_DIV: begin
				mul_a = $signed(RECIP_THREE);
				mul_b = $signed({1'b0, sum_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer, tracker state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			avg_q       <= '0;
			trend_q     <= '0;
			hist0_q     <= '0;
			hist1_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop a taken result unless the next one loads this cycle
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						echo_q  <= echo_width;
						state_q <= S_DIST;
					end
				end
				S_DIST:   state_q <= S_CLAMP;
				S_CLAMP: begin
					dist_q  <= dist_c;
					state_q <= S_HEIGHT;
				end
				S_HEIGHT: begin
					height_q <= height_c;
					state_q  <= S_AVG;
				end
				S_AVG:    state_q <= S_UPD;
				S_UPD: begin
					avg_q   <= avg_q + prod[30:15];
					sum_q   <= {2'b0, height_q} + {2'b0, hist0_q} + {2'b0, hist1_q};
					hist1_q <= hist0_q;
					hist0_q <= height_q;
					count_q <= count_next;
					state_q <= S_DIV;
				end
				S_DIV:    state_q <= S_TREND;
				S_TREND: begin
					if (count_q >= cfg.trend_start_count)
						trend_q <= {1'b0, quot} - {1'b0, avg_q};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_dist_q   <= dist_q;
						out_height_q <= height_q;
						out_avg_q    <= avg_q;
						out_trend_q  <= trend_q;
						out_class_q  <= class_c;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign distance        = out_dist_q;
	assign water_height    = out_height_q;
	assign smoothed_height = out_avg_q;
	assign height_trend    = out_trend_q;
	assign level_class     = out_class_q;

endmodule
`default_nettype wire

// File: dv/echo_level_tracker_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for echo_level_tracker: directed corners, random settings, backpressure.
module echo_level_tracker_tb;
	import elt_pkg::*;

	localparam int HIST_DEPTH = 16;
	localparam int COUNT_CAP = (HIST_DEPTH > 31) ? 31 : HIST_DEPTH;
	// margin for the sequencer to reach idle before a register write
	localparam int SETTLE_CYCLES = 12;
	localparam int TAIL_CYCLES = 20;
	// longest quiet stretch: the hold-off plus a refill and the longest sender gap
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLDOFF_CYCLES = 200;
	localparam int RANDOM_PHASES = 14;
	localparam int ECHOES_PER_PHASE = 100;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [15:0]  dist_cm;
		logic [15:0]  height;
		logic [15:0]  avg;
		logic [16:0]  trend;
		level_class_t cls;
	} level_result_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	// block inputs
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic [15:0] echo_width = '0;
	logic        out_stall = 1'b0;

	// block outputs
	logic        in_stall;
	logic        out_valid;
	logic [15:0] distance;
	logic [15:0] water_height;
	logic [15:0] smoothed_height;
	logic [16:0] height_trend;
	logic [1:0]  level_class;

	echo_level_tracker #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.echo_width(echo_width),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance(distance),
		.water_height(water_height),
		.smoothed_height(smoothed_height),
		.height_trend(height_trend),
		.level_class(level_class)
	);

	// predictor state: register shadow and tracker history
	cfg_t              cfg_shadow;
	logic [15:0]       avg_state = '0;
	logic [16:0]       trend_state = '0;
	logic [15:0]       recent_h [3] = '{16'd0, 16'd0, 16'd0};
	int unsigned       samples_seen = 0;
	level_result_t     pending_levels [$];

	// run control and statistics
	int  tx_mode = 0;       // 0: back to back, 1: bursts with gaps
	int  rx_mode = 0;       // 0: never, 1: light, 2: heavy, 3: fixed pattern
	bit  holdoff_req = 1'b0;
	int  last_echo = 0;
	int  echoes_sent = 0;
	int  results_seen = 0;
	int  settings_used = 0;
	int  mismatches = 0;
	int  idle_cycles = 0;
	level_result_t head_level;

	// expected result for one accepted echo word; advances the predictor state
	function automatic level_result_t track_echo(input logic [15:0] e);
		logic [63:0]   raw;
		logic [15:0]   dist_cm;
		logic [15:0]   h;
		logic [15:0]   w;
		logic [63:0]   mix;
		int            hs;
		int            t;
		int unsigned   sum;
		level_result_t r;
		raw = '0;
		if (e > ECHO_LOW && e < ECHO_HIGH) begin
			raw = (64'(e) * 64'(cfg_shadow.sound_speed) * 64'd50) >> 16;
		end
		// distance clamp; with crossed clamps raw below min gives min, any other raw gives max
		if (raw < 64'(cfg_shadow.min_distance)) begin
			dist_cm = cfg_shadow.min_distance;
		end else if (raw > 64'(cfg_shadow.max_distance)) begin
			dist_cm = cfg_shadow.max_distance;
		end else begin
			dist_cm = raw[15:0];
		end
		hs = int'({16'h0, cfg_shadow.tank_height}) - int'({16'h0, dist_cm})
			+ int'({16'h0, cfg_shadow.sensor_offset});
		if (hs < 0) begin
			h = '0;
		end else if (hs > int'({16'h0, cfg_shadow.tank_height})) begin
			h = cfg_shadow.tank_height;
		end else begin
			h = hs[15:0];
		end
		// moving average, weight saturated at one
		w = (cfg_shadow.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_shadow.smoothing_weight;
		mix = (64'(w) * 64'(h) + 64'(WEIGHT_ONE - w) * 64'(avg_state)) >> 15;
		avg_state = mix[15:0];
		recent_h[2] = recent_h[1];
		recent_h[1] = recent_h[0];
		recent_h[0] = h;
		if (samples_seen < COUNT_CAP) begin
			samples_seen++;
		end
		if (samples_seen >= cfg_shadow.trend_start_count) begin
			sum = recent_h[0] + recent_h[1] + recent_h[2];
			t = int'(sum / 3) - int'({16'h0, avg_state});
			trend_state = t[16:0];
		end
		r.dist_cm = dist_cm;
		r.height = h;
		r.avg = avg_state;
		r.trend = trend_state;
		if (h > CLASS_HIGH_ABOVE) begin
			r.cls = CLASS_HIGH;
		end else if (h > CLASS_MED_ABOVE) begin
			r.cls = CLASS_MEDIUM;
		end else if (dist_cm <= CLASS_LOW_DIST) begin
			r.cls = CLASS_LOW;
		end else begin
			r.cls = CLASS_EMPTY;
		end
		return r;
	endfunction

	// echo widths that mostly land inside the tank, plus edges and noise
	function automatic logic [15:0] pick_echo();
		longint span;
		int     sel;
		int     v;
		if (cfg_shadow.sound_speed == 0) begin
			span = 44999;
		end else begin
			span = (longint'(cfg_shadow.tank_height) + longint'(cfg_shadow.sensor_offset)) * 65536
				/ (longint'(cfg_shadow.sound_speed) * 50) + 2;
		end
		if (span < 102) span = 102;
		if (span > 44999) span = 44999;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			v = $urandom_range(int'(span), 101);
		end else if (sel < 6) begin
			v = last_echo + int'($urandom_range(0, 40)) - 20;
			if (v < 0) v = 0;
			if (v > 65535) v = 65535;
		end else if (sel == 6) begin
			case ($urandom_range(0, 10))
				0: v = 0;
				1: v = 1;
				2: v = 99;
				3: v = 100;
				4: v = 101;
				5: v = 102;
				6: v = 44998;
				7: v = 44999;
				8: v = 45000;
				9: v = 45001;
				default: v = 65535;
			endcase
		end else if (sel == 7) begin
			v = 0;
		end else begin
			v = int'($urandom_range(0, 65535));
		end
		last_echo = v;
		return v[15:0];
	endfunction

	// register value: mostly a realistic range, sometimes an extreme or noise
	function automatic logic [15:0] spread(input int lo, input int hi,
		input logic [15:0] ext_lo, input logic [15:0] ext_hi);
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 3) return ext_lo;
		if (sel < 6) return ext_hi;
		if (sel < 8) return 16'($urandom);
		return 16'($urandom_range(hi, lo));
	endfunction

	// one echo word: hold it until taken, then queue its expected result
	task automatic send_echo(input logic [15:0] e);
		in_valid <= 1'b1;
		echo_width <= e;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_levels.push_back(track_echo(e));
		echoes_sent++;
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// block idle: every result back and the sequencer done
	task automatic settle();
		pause_sender(1);
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SOUND_SPEED:   cfg_shadow.sound_speed = val;
			REG_MIN_DISTANCE:  cfg_shadow.min_distance = val;
			REG_MAX_DISTANCE:  cfg_shadow.max_distance = val;
			REG_TANK_HEIGHT:   cfg_shadow.tank_height = val;
			REG_SENSOR_OFFSET: cfg_shadow.sensor_offset = val;
			REG_SMOOTH_WEIGHT: cfg_shadow.smoothing_weight = val;
			REG_TREND_START:   cfg_shadow.trend_start_count = val[4:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] speed, input logic [15:0] dmin,
		input logic [15:0] dmax, input logic [15:0] tank, input logic [15:0] offs,
		input logic [15:0] wt, input logic [15:0] tstart);
		settle();
		write_reg(REG_SOUND_SPEED, speed);
		write_reg(REG_MIN_DISTANCE, dmin);
		write_reg(REG_MAX_DISTANCE, dmax);
		write_reg(REG_TANK_HEIGHT, tank);
		write_reg(REG_SENSOR_OFFSET, offs);
		write_reg(REG_SMOOTH_WEIGHT, wt);
		write_reg(REG_TREND_START, tstart);
		settings_used++;
	endtask

	task automatic run_echoes(input int n);
		int i;
		int k;
		int burst;
		i = 0;
		while (i < n) begin
			burst = (tx_mode != 0) ? $urandom_range(1, 12) : n;
			for (k = 0; k < burst && i < n; k++) begin
				send_echo(pick_echo());
				i++;
			end
			if (tx_mode != 0) pause_sender($urandom_range(1, 16));
		end
	endtask

	// reset values, timeouts, window edges, early trend with empty history
	task automatic test_reset_defaults();
		send_echo(16'd0);
		send_echo(16'd100);
		send_echo(16'd101);
		send_echo(16'd44999);
		send_echo(16'd45000);
		send_echo(16'd65535);
		send_echo(16'd300);
		send_echo(16'd3000);
	endtask

	// crossed clamps, full-scale speed, offset and tank, weight above one, trend start zero
	task automatic test_extreme_settings();
		apply_settings(16'hFFFF, 16'd5000, 16'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFE0);
		send_echo(16'd0);
		send_echo(16'd101);
		send_echo(16'd44999);
		send_echo(16'd120);
	endtask

	// zero speed, zero tank, zero weight, trend start never reached
	task automatic test_zeroed_settings();
		apply_settings(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd31);
		send_echo(16'd0);
		send_echo(16'd4000);
		send_echo(16'hFFFF);
	endtask

	// speed 1311 makes distance equal the echo width; step across class bounds
	task automatic test_class_thresholds();
		apply_settings(16'd1311, 16'd0, 16'hFFFF, 16'd950, 16'd0, 16'd32768, 16'd1);
		send_echo(16'd649);
		send_echo(16'd650);
		send_echo(16'd799);
		send_echo(16'd800);
		send_echo(16'd801);
	endtask

	task automatic test_random_settings();
		int p;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			apply_settings(spread(1800, 2600, 16'd0, 16'hFFFF),
				spread(0, 1500, 16'd0, 16'hFFFF),
				spread(5000, 60000, 16'd0, 16'hFFFF),
				spread(500, 20000, 16'd0, 16'hFFFF),
				spread(0, 2000, 16'd0, 16'hFFFF),
				spread(1, 32767, 16'd0, 16'd32768),
				{5'($urandom_range(0, 31)) == 5'd0 ? 11'h7FF : 11'($urandom), 5'(
					($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16))});
			tx_mode = (p == 0) ? 0 : $urandom_range(0, 1);
			rx_mode = (p == 0) ? 0 : $urandom_range(0, 3);
			run_echoes(ECHOES_PER_PHASE);
		end
	endtask

	// long receiver hold-off with the sender pushing, a full drain, then bursts under heavy stalls
	task automatic test_backpressure();
		apply_settings(RST_SOUND_SPEED, RST_MIN_DISTANCE, RST_MAX_DISTANCE, 16'd5000,
			16'd250, RST_SMOOTH_WEIGHT, 16'(RST_TREND_START));
		tx_mode = 0;
		rx_mode = 0;
		holdoff_req = 1'b1;
		run_echoes(30);
		pause_sender(1);
		while (pending_levels.size() != 0) @(posedge clk);
		tx_mode = 1;
		rx_mode = 2;
		run_echoes(40);
		settle();
	endtask

	// receiver: stall pattern per mode, or a counted hold-off on request
	initial begin : receiver
		int hold_n;
		int tick;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (holdoff_req) begin
				out_stall <= 1'b1;
				for (hold_n = 0; hold_n < HOLDOFF_CYCLES; hold_n++) @(posedge clk);
				holdoff_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				case (rx_mode)
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					3: out_stall <= ((tick % 11) < 4);
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	// result checker: oldest expectation against each accepted result word
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] result word with nothing expected: dist=%0d h=%0d", $realtime,
						distance, water_height);
			end else begin
				head_level = pending_levels.pop_front();
				if (distance !== head_level.dist_cm || water_height !== head_level.height ||
					smoothed_height !== head_level.avg || height_trend !== head_level.trend ||
					level_class !== head_level.cls) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"[%0t] result %0d mismatch: exp dist=%0d h=%0d avg=%0d ",
							"trend=%0d cls=%0d | got dist=%0d h=%0d avg=%0d trend=%0d cls=%0d"},
							$realtime, results_seen, head_level.dist_cm, head_level.height,
							head_level.avg, $signed(head_level.trend), head_level.cls,
							distance, water_height, smoothed_height, $signed(height_trend),
							level_class);
				end
			end
		end
	end

	// watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no word moved for %0d cycles", idle_cycles);
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		cfg_shadow.sound_speed = RST_SOUND_SPEED;
		cfg_shadow.min_distance = RST_MIN_DISTANCE;
		cfg_shadow.max_distance = RST_MAX_DISTANCE;
		cfg_shadow.tank_height = RST_TANK_HEIGHT;
		cfg_shadow.sensor_offset = RST_SENSOR_OFFSET;
		cfg_shadow.smoothing_weight = RST_SMOOTH_WEIGHT;
		cfg_shadow.trend_start_count = RST_TREND_START;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_extreme_settings();
		test_zeroed_settings();
		test_class_thresholds();
		test_random_settings();
		test_backpressure();

		pause_sender(1);
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_levels.size() != 0) begin
			$display("%0d expected results never arrived", pending_levels.size());
			mismatches += pending_levels.size();
		end

		$display("Sent %0d echo words, checked %0d results across %0d register settings,",
			echoes_sent, results_seen, settings_used + 1);
		$display("incl. crossed clamps, zero tank, weight above one, trend start 0 and 31, hold-off.");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/elt_pkg.sv
rtl/elt_cfg.sv
rtl/elt_mul.sv
rtl/echo_level_tracker.sv
dv/echo_level_tracker_tb.sv
